FILE: design/atr_pkg.sv
// Shared constants, word types and control structs for the average true range block.
`default_nettype none

package atr_pkg;

    // Field widths of the bar and result words
    localparam int PRICE_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_PERIOD  = 1024;
    localparam int PERIOD_BITS = 11;
    localparam int ATR_BITS    = PRICE_BITS + FRAC_BITS;

    // Derived datapath widths
    localparam int PM1_BITS  = $clog2(MAX_PERIOD);
    localparam int SUM_BITS  = PRICE_BITS + PM1_BITS;
    localparam int HALF_BITS = ATR_BITS / 2;
    localparam int PROD_BITS = (ATR_BITS - HALF_BITS) + PM1_BITS;
    localparam int DIV_BITS  = ATR_BITS + PM1_BITS + 1;
    localparam int CNT_BITS  = $clog2(DIV_BITS + 1);

    // Reset value of the period register
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);

    typedef struct packed {
        logic [PRICE_BITS-1:0] high;
        logic [PRICE_BITS-1:0] low;
        logic [PRICE_BITS-1:0] close;
        logic                  restart;
    } t_in_word;

    typedef struct packed {
        logic [ATR_BITS-1:0] atr;
        logic                seed;
    } t_out_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic mul_lo;
        logic mul_hi;
        logic div_start;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic first;
        logic emit;
        logic seed;
        logic div_done;
        logic out_free;
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_LOAD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/atr_div.sv
// Restoring divider, one quotient bit per cycle, dividing by the live period.
`default_nettype none

module atr_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [atr_pkg::DIV_BITS-1:0]         i_dividend,
    input  wire [atr_pkg::PERIOD_BITS-1:0]      i_divisor,
    output logic                                o_done,
    output logic [atr_pkg::DIV_BITS-1:0]        o_quotient
);

    logic [atr_pkg::DIV_BITS-1:0]    r_q, n_q;
    logic [atr_pkg::PERIOD_BITS-1:0] r_r, n_r;
    logic [atr_pkg::CNT_BITS-1:0]    r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;

    logic [atr_pkg::PERIOD_BITS:0]   trial;
    logic                            fits;

    // One shift-subtract step
    always_comb begin
        trial = {r_r, r_q[atr_pkg::DIV_BITS-1]};
        fits  = trial >= {1'b0, i_divisor};
        n_q    = r_q;
        n_r    = r_r;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_r    = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[atr_pkg::DIV_BITS-2:0], fits};
            n_r   = fits ? atr_pkg::PERIOD_BITS'(trial - {1'b0, i_divisor})
                         : trial[atr_pkg::PERIOD_BITS-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == atr_pkg::CNT_BITS'(atr_pkg::DIV_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_r <= n_r;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

FILE: design/atr_dp.sv
// Datapath: series state, true range, split multiplier, divider and output register.
`default_nettype none

module atr_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  atr_pkg::t_cmd                     i_cmd,
    output atr_pkg::t_status                  o_status,
    input  wire [atr_pkg::PERIOD_BITS-1:0]    i_period,
    input  atr_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output atr_pkg::t_out_word                o_out_word
);

    atr_pkg::t_in_word               r_bar;
    logic [atr_pkg::PRICE_BITS-1:0]  r_prior_close;
    logic                            r_has_prior;
    logic [atr_pkg::PERIOD_BITS-1:0] r_range_count;
    logic [atr_pkg::SUM_BITS-1:0]    r_range_sum;
    logic [atr_pkg::ATR_BITS-1:0]    r_average;
    logic [atr_pkg::PRICE_BITS-1:0]  r_tr;
    logic                            r_seed;
    logic [atr_pkg::PROD_BITS-1:0]   r_prod_lo;
    logic [atr_pkg::PROD_BITS-1:0]   r_prod_hi;
    logic                            r_out_valid;
    atr_pkg::t_out_word              r_out_word;

    logic [atr_pkg::PRICE_BITS-1:0]  gap_hi, gap_lo, spread, tr;
    logic [atr_pkg::PM1_BITS-1:0]    pm1;
    logic [atr_pkg::PROD_BITS-1:0]   mul_a, mul_y;
    logic [atr_pkg::PERIOD_BITS:0]   count_inc;
    logic                            below, seed_now, first;
    logic [atr_pkg::DIV_BITS-1:0]    dividend;
    logic                            div_done;
    logic [atr_pkg::DIV_BITS-1:0]    quotient;
    logic                            out_free;

    // True range against the prior close
    always_comb begin
        gap_hi = (r_bar.high >= r_prior_close) ? r_bar.high - r_prior_close
                                               : r_prior_close - r_bar.high;
        gap_lo = (r_bar.low >= r_prior_close) ? r_bar.low - r_prior_close
                                              : r_prior_close - r_bar.low;
        spread = r_bar.high - r_bar.low;
        tr     = (gap_lo > gap_hi) ? gap_lo : gap_hi;
        if (r_bar.high >= r_bar.low && spread > tr) begin
            tr = spread;
        end
    end

    // Bar classification
    always_comb begin
        first     = r_bar.restart || !r_has_prior;
        count_inc = {1'b0, r_range_count} + 1'b1;
        below     = r_range_count < i_period;
        seed_now  = below && (count_inc == {1'b0, i_period});
    end

    // Shared 24 x 10 multiplier: average times (period - 1), one half a cycle
    assign pm1   = atr_pkg::PM1_BITS'(i_period - 1'b1);
    assign mul_a = i_cmd.mul_hi
                 ? atr_pkg::PROD_BITS'(r_average[atr_pkg::ATR_BITS-1:atr_pkg::HALF_BITS])
                 : atr_pkg::PROD_BITS'(r_average[atr_pkg::HALF_BITS-1:0]);
    assign mul_y = mul_a * atr_pkg::PROD_BITS'(pm1);

    // Dividend: scaled sum for the seed, Wilder numerator otherwise
    always_comb begin
        if (r_seed) begin
            dividend = atr_pkg::DIV_BITS'({r_range_sum, {atr_pkg::FRAC_BITS{1'b0}}});
        end else begin
            dividend = (atr_pkg::DIV_BITS'(r_prod_hi) << atr_pkg::HALF_BITS)
                     + atr_pkg::DIV_BITS'(r_prod_lo)
                     + atr_pkg::DIV_BITS'({r_tr, {atr_pkg::FRAC_BITS{1'b0}}});
        end
    end

    atr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (i_period),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_close <= '0;
            r_has_prior   <= 1'b0;
            r_range_count <= '0;
            r_range_sum   <= '0;
            r_average     <= '0;
            r_seed        <= 1'b0;
        end else if (i_cmd.eval) begin
            r_prior_close <= r_bar.close;
            r_has_prior   <= 1'b1;
            if (first) begin
                r_range_count <= '0;
                r_range_sum   <= '0;
                r_average     <= '0;
            end else begin
                r_seed <= seed_now;
                if (below) begin
                    r_range_count <= count_inc[atr_pkg::PERIOD_BITS-1:0];
                    r_range_sum   <= r_range_sum + atr_pkg::SUM_BITS'(tr);
                end
            end
        end else if (i_cmd.finish) begin
            r_average <= quotient[atr_pkg::ATR_BITS-1:0];
        end
    end

    // Bar latch, range and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bar <= i_in_word;
        end
        if (i_cmd.eval) begin
            r_tr <= tr;
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= mul_y;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= mul_y;
        end
    end

    // Output register: frees the input side while a result waits
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_word.atr  <= quotient[atr_pkg::ATR_BITS-1:0];
            r_out_word.seed <= r_seed;
        end
    end

    assign o_status.first    = first;
    assign o_status.emit     = !first && (!below || seed_now);
    assign o_status.seed     = seed_now;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    // A result is only written into a free output register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> out_free)
        else $error("result loaded over an undelivered word");

    // A restart bar, or the first bar after reset, clears the series and leaves a held close
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && first) |=> (r_has_prior && r_range_count == '0
                                   && r_range_sum == '0 && r_average == '0))
        else $error("restart bar left stale series state");

    // The delivered seed flag follows the bar that produced it
    a_seed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_valid && r_out_word.seed == $past(r_seed)))
        else $error("output word seed flag mismatch");

endmodule

`default_nettype wire

FILE: design/atr_ctrl.sv
// Controller state machine sequencing range, multiply, divide and delivery.
`default_nettype none

module atr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  atr_pkg::t_status  i_status,
    output atr_pkg::t_cmd     o_cmd
);

    atr_pkg::t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            atr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = atr_pkg::S_EVAL;
                end
            end
            atr_pkg::S_EVAL: begin
                priority if (!i_status.emit) begin
                    n_state = atr_pkg::S_IDLE;
                end else if (i_status.seed) begin
                    n_state = atr_pkg::S_DIV_LOAD;
                end else begin
                    n_state = atr_pkg::S_MUL_LO;
                end
            end
            atr_pkg::S_MUL_LO:   n_state = atr_pkg::S_MUL_HI;
            atr_pkg::S_MUL_HI:   n_state = atr_pkg::S_DIV_LOAD;
            atr_pkg::S_DIV_LOAD: n_state = atr_pkg::S_DIV;
            atr_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = atr_pkg::S_DONE;
                end
            end
            atr_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = atr_pkg::S_IDLE;
                end
            end
            default: n_state = atr_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd           = '0;
        o_in_stall      = (r_state != atr_pkg::S_IDLE);
        o_cmd.load      = (r_state == atr_pkg::S_IDLE) && i_in_valid;
        o_cmd.eval      = (r_state == atr_pkg::S_EVAL);
        o_cmd.mul_lo    = (r_state == atr_pkg::S_MUL_LO);
        o_cmd.mul_hi    = (r_state == atr_pkg::S_MUL_HI);
        o_cmd.div_start = (r_state == atr_pkg::S_DIV_LOAD);
        o_cmd.finish    = (r_state == atr_pkg::S_DONE) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: design/average_true_range_top.sv
// Top level of the Wilder average true range block: period register and unit wiring.
//
// Use: bars arrive on the input channel (i_in_valid / o_in_stall, word
// i_in_word); a word is taken at an edge with valid high and stall low.
// Results leave on the output channel (o_out_valid / i_out_stall, word
// o_out_word) with the same rule, the receiver driving stall.
// The user writes the period (i_cfg_valid / o_cfg_ready / i_cfg_data) only while
// idle, which the block does not enforce; zero acts as 1, above 1024 as 1024.
// Flow: one bar at a time. A bar that gives no result stalls the input only
// while it is evaluated. A seed result comes from the evaluation, then the
// 59-step one-bit-per-cycle period divider; a smoothed result also passes the
// low and high halves of the split 24 x 10 multiplier before the divide. The
// next bar is taken once a result is written into the output register.
// The output register holds a result while i_out_stall is high; the next bar
// is still taken and worked on, and waits only to write its own result.
// Reset clears the series (no close held), sets the period to 14 and
// empties the output register.
`default_nettype none

module average_true_range_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  atr_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output atr_pkg::t_out_word               o_out_word,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [atr_pkg::PERIOD_BITS-1:0]   i_cfg_data
);

    logic [atr_pkg::PERIOD_BITS-1:0] r_period;
    logic [atr_pkg::PERIOD_BITS-1:0] live_period;
    atr_pkg::t_cmd                   cmd;
    atr_pkg::t_status                status;

    // Period register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= atr_pkg::PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_period <= i_cfg_data;
        end
    end

    // Clamp the period into one to the maximum
    always_comb begin
        priority if (r_period == '0) begin
            live_period = atr_pkg::PERIOD_BITS'(1);
        end else if (r_period > atr_pkg::PERIOD_BITS'(atr_pkg::MAX_PERIOD)) begin
            live_period = atr_pkg::PERIOD_BITS'(atr_pkg::MAX_PERIOD);
        end else begin
            live_period = r_period;
        end
    end

    atr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    atr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_period    (live_period),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
